@@ rtl/obem_pkg.sv @@
// Types, constants and build-time coefficient helpers for the octave band envelope meter.
// No dependencies.
`default_nettype none

package obem_pkg;

    localparam int MAX_BANDS = 8;
    localparam int BAND_W    = 3;

    localparam logic [22:0] LEVEL_MAX     = 23'h7FFFFF;
    localparam logic [23:0] ATTACK_RESET  = 24'd29102;
    localparam logic [23:0] RELEASE_RESET = 24'd1589;
    localparam logic [16:0] DECAY_ONE     = 17'd65536;

    // register indexes on the configuration port
    localparam logic REG_ATTACK  = 1'b0;
    localparam logic REG_RELEASE = 1'b1;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q28  = 64'sd1686629713;

    localparam longint CENTRE_HZ [MAX_BANDS] = '{60, 120, 250, 500, 1000, 2000, 4000, 8000};
    localparam longint SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
    localparam longint COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_M0,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_M4,
        OP_FILT,
        OP_LVL,
        OP_EMUL,
        OP_ENV,
        OP_DMUL,
        OP_DWR,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [BAND_W-1:0]   band;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_FILT,
        ST_LVL,
        ST_EMUL,
        ST_ENV,
        ST_DMUL,
        ST_DWR,
        ST_OUT
    } ctrl_state_t;

    // Q2.30 sine by a nine-term series, truncating each term
    function automatic longint taylor_sin(input longint x);
        longint x2;
        longint term;
        longint s;
        begin
            x2   = (x * x) >>> 30;
            term = x;
            s    = x;
            for (int n = 0; n < 8; n++)
            begin
                term = ((term * x2) >>> 30) / SIN_DIV[n];
                if (n % 2 == 0)
                    s = s - term;
                else
                    s = s + term;
            end
            return s;
        end
    endfunction

    // Q2.30 cosine by a nine-term series, truncating each term
    function automatic longint taylor_cos(input longint x);
        longint x2;
        longint term;
        longint c;
        begin
            x2   = (x * x) >>> 30;
            term = ONE_Q30;
            c    = ONE_Q30;
            for (int n = 0; n < 8; n++)
            begin
                term = ((term * x2) >>> 30) / COS_DIV[n];
                if (n % 2 == 0)
                    c = c - term;
                else
                    c = c + term;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/obem_if.sv @@
// Request and result channel interfaces of the octave band envelope meter.
// No dependencies.
`default_nettype none

interface obem_item_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [23:0] sample;
    logic [16:0]        decay_factor;

    modport source (output valid, op, sample, decay_factor, input ready);
    modport sink   (input valid, op, sample, decay_factor, output ready);
endinterface

interface obem_result_if;
    logic        valid;
    logic        ready;
    logic [22:0] env_band_0;
    logic [22:0] env_band_1;
    logic [22:0] env_band_2;
    logic [22:0] env_band_3;
    logic [22:0] env_band_4;
    logic [22:0] env_band_5;
    logic [22:0] env_band_6;
    logic [22:0] env_band_7;

    modport source (output valid, env_band_0, env_band_1, env_band_2, env_band_3,
                    env_band_4, env_band_5, env_band_6, env_band_7, input ready);
    modport sink   (input valid, env_band_0, env_band_1, env_band_2, env_band_3,
                    env_band_4, env_band_5, env_band_6, env_band_7, output ready);
endinterface

`default_nettype wire

@@ rtl/obem_ctrl.sv @@
// Sequencer of the octave band envelope meter: steps the datapath band by band.
// Depends on obem_pkg.
`default_nettype none

module obem_ctrl
    import obem_pkg::*;
#(
    parameter int NUM_BANDS = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    input  wire logic item_op,
    output logic      item_ready,
    output logic      res_valid,
    input  wire logic res_ready,
    output dp_cmd_t   cmd
);

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

    ctrl_state_t       state_reg, state_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              res_valid_reg, res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        band_next      = band_reg;
        res_valid_next = res_valid_reg && !res_ready;
        item_ready     = 1'b0;
        cmd.op         = OP_NOP;
        cmd.band       = band_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.op     = OP_LOAD;
                    band_next  = '0;
                    state_next = item_op ? ST_DMUL : ST_M0;
                end
            end
            ST_M0:
            begin
                cmd.op     = OP_M0;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.op     = OP_M1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op     = OP_M2;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cmd.op     = OP_M3;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                cmd.op     = OP_M4;
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.op     = OP_FILT;
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                cmd.op     = OP_LVL;
                state_next = ST_EMUL;
            end
            ST_EMUL:
            begin
                cmd.op     = OP_EMUL;
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                cmd.op = OP_ENV;
                if (band_reg == LAST_BAND)
                    state_next = ST_OUT;
                else
                begin
                    band_next  = band_reg + 1'b1;
                    state_next = ST_M0;
                end
            end
            ST_DMUL:
            begin
                cmd.op     = OP_DMUL;
                state_next = ST_DWR;
            end
            ST_DWR:
            begin
                cmd.op = OP_DWR;
                if (band_reg == LAST_BAND)
                    state_next = ST_OUT;
                else
                begin
                    band_next  = band_reg + 1'b1;
                    state_next = ST_DMUL;
                end
            end
            ST_OUT:
            begin
                // hold until the previous result has left
                if (!res_valid_reg || res_ready)
                begin
                    cmd.op         = OP_OUT;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

@@ rtl/obem_dp.sv @@
// Datapath of the octave band envelope meter: coefficient table, filter history,
// envelopes, one shared multiplier and the result register. Depends on obem_pkg.
`default_nettype none

module obem_dp
    import obem_pkg::*;
#(
    parameter int SAMPLE_RATE = 48000,
    parameter int NUM_BANDS   = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic signed [23:0] sample,
    input  wire logic [16:0]        decay_factor,
    input  wire logic [23:0]        attack_coeff,
    input  wire logic [23:0]        release_coeff,
    output logic [22:0]             env_out [MAX_BANDS]
);

    logic signed [31:0] cb0 [MAX_BANDS];
    logic signed [31:0] ca1 [MAX_BANDS];
    logic signed [31:0] ca2 [MAX_BANDS];

    // bandpass coefficients, worked out at elaboration
    for (genvar g = 0; g < MAX_BANDS; g++)
    begin : g_coef
        localparam bit     CAP    = 20 * CENTRE_HZ[g] > 9 * longint'(SAMPLE_RATE);
        localparam longint NUM    = CAP ? 64'sd9 : CENTRE_HZ[g];
        localparam longint DEN    = CAP ? 64'sd40 : longint'(SAMPLE_RATE);
        localparam longint TURNS  = (NUM <<< 32) / DEN;
        localparam longint W0     = (TURNS * TWO_PI_Q28) >>> 30;
        localparam bit     FLIP   = W0 > HALF_PI_Q30;
        localparam longint XR     = FLIP ? PI_Q30 - W0 : W0;
        localparam longint SRAW   = taylor_sin(XR);
        localparam longint SN     = SRAW < 0 ? 64'sd0 : SRAW;
        localparam longint CRAW   = taylor_cos(XR);
        localparam longint CS     = FLIP ? -CRAW : CRAW;
        localparam longint CMAG   = CS < 0 ? -CS : CS;
        localparam longint ALPHA  = (SN * 5 + 7) / 14;
        localparam longint A0     = ONE_Q30 + ALPHA;
        localparam longint B0     = ((ALPHA <<< 28) + A0 / 2) / A0;
        localparam longint CM     = (((2 * CMAG) <<< 28) + A0 / 2) / A0;
        localparam longint A1     = CS < 0 ? CM : -CM;
        localparam longint A2     = (((ONE_Q30 - ALPHA) <<< 28) + A0 / 2) / A0;

        assign cb0[g] = 32'(B0);
        assign ca1[g] = 32'(A1);
        assign ca2[g] = 32'(A2);
    end

    logic signed [23:0] x_reg;
    logic [16:0]        f_reg;
    logic signed [57:0] prod_reg;
    logic signed [57:0] acc_reg;
    logic signed [23:0] y_reg;
    logic [22:0]        dmag_reg;
    logic               up_reg;
    logic [23:0]        k_reg;
    logic signed [23:0] hx1_reg [MAX_BANDS];
    logic signed [23:0] hx2_reg [MAX_BANDS];
    logic signed [23:0] hy1_reg [MAX_BANDS];
    logic signed [23:0] hy2_reg [MAX_BANDS];
    logic [22:0]        env_reg [MAX_BANDS];
    logic [22:0]        res_reg [MAX_BANDS];

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;

    logic [BAND_W-1:0]  bnd;
    assign bnd = cmd.band;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_M0:
            begin
                mul_a = 33'(cb0[bnd]);
                mul_b = 25'(x_reg);
            end
            OP_M1:
            begin
                mul_a = 33'(cb0[bnd]);
                mul_b = 25'(hx2_reg[bnd]);
            end
            OP_M2:
            begin
                mul_a = 33'(ca1[bnd]);
                mul_b = 25'(hy1_reg[bnd]);
            end
            OP_M3:
            begin
                mul_a = 33'(ca2[bnd]);
                mul_b = 25'(hy2_reg[bnd]);
            end
            OP_EMUL:
            begin
                mul_a = $signed({10'b0, dmag_reg});
                mul_b = $signed({1'b0, k_reg});
            end
            OP_DMUL:
            begin
                mul_a = $signed({10'b0, env_reg[bnd]});
                mul_b = $signed({8'b0, f_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // filter output: round, then saturate to Q1.23
    logic signed [57:0] rnd_t;
    logic signed [29:0] rnd_q;
    logic signed [23:0] y_sat;
    assign rnd_t = acc_reg + 58'sd134217728;
    assign rnd_q = rnd_t[57:28];

    always_comb
    begin
        if (rnd_q > 30'sd8388607)
            y_sat = 24'sh7FFFFF;
        else if (rnd_q < -30'sd8388608)
            y_sat = 24'sh800000;
        else
            y_sat = rnd_q[23:0];
    end

    // level and distance to the envelope
    logic [24:0] y_abs;
    logic [22:0] lvl;
    logic [22:0] env_cur;
    logic        lvl_up;
    assign y_abs   = y_reg[23] ? 25'(-$signed({y_reg[23], y_reg})) : {1'b0, y_reg};
    assign lvl     = (y_abs > 25'(LEVEL_MAX)) ? LEVEL_MAX : y_abs[22:0];
    assign env_cur = env_reg[bnd];
    assign lvl_up  = lvl > env_cur;

    // envelope step
    logic [57:0] step_t;
    logic [23:0] step;
    logic [24:0] env_sum;
    logic [22:0] env_new;
    assign step_t  = prod_reg + 58'sd8388608;
    assign step    = step_t[47:24];
    assign env_sum = {2'b0, env_cur} + {1'b0, step};

    always_comb
    begin
        if (up_reg)
            env_new = (env_sum > 25'(LEVEL_MAX)) ? LEVEL_MAX : env_sum[22:0];
        else if (step > {1'b0, env_cur})
            env_new = '0;
        else
            env_new = env_cur - step[22:0];
    end

    logic [57:0] dec_t;
    assign dec_t = prod_reg + 58'sd32768;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                x_reg <= sample;
                f_reg <= (decay_factor > DECAY_ONE) ? DECAY_ONE : decay_factor;
            end
            OP_M0, OP_M2, OP_M3, OP_EMUL, OP_DMUL:
            begin
                prod_reg <= mul_p;
                if (cmd.op == OP_M2 || cmd.op == OP_M3)
                    acc_reg <= acc_reg - prod_reg;
            end
            OP_M1:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_M4:
            begin
                acc_reg <= acc_reg - prod_reg;
            end
            OP_FILT:
            begin
                y_reg <= y_sat;
            end
            OP_LVL:
            begin
                up_reg   <= lvl_up;
                dmag_reg <= lvl_up ? lvl - env_cur : env_cur - lvl;
                k_reg    <= lvl_up ? attack_coeff : release_coeff;
            end
            OP_NOP, OP_ENV, OP_DWR, OP_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // filter history and envelopes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                hx1_reg[i] <= '0;
                hx2_reg[i] <= '0;
                hy1_reg[i] <= '0;
                hy2_reg[i] <= '0;
                env_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_FILT)
            begin
                hx2_reg[bnd] <= hx1_reg[bnd];
                hx1_reg[bnd] <= x_reg;
                hy2_reg[bnd] <= hy1_reg[bnd];
                hy1_reg[bnd] <= y_sat;
            end
            if (cmd.op == OP_ENV)
                env_reg[bnd] <= env_new;
            if (cmd.op == OP_DWR)
                env_reg[bnd] <= dec_t[38:16];
        end
    end

    // result register, unused bands read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            for (int i = 0; i < MAX_BANDS; i++)
                res_reg[i] <= (i < NUM_BANDS) ? env_reg[i] : '0;
        end
    end

    assign env_out = res_reg;

endmodule

`default_nettype wire

@@ rtl/octave_band_envelope_meter_top.sv @@
// Octave band envelope meter: every band of a sample passes through the one shared
// multiplier, which every filter tap and envelope step uses; a decay request also
// steps through the bands one by one.
// The next request is taken in the cycle after the result is loaded, while that
// result waits. Reset (rst_n, asynchronous, active low) clears filter history and
// envelopes and restores the default attack and release factors.
`default_nettype none

module octave_band_envelope_meter_top
    import obem_pkg::*;
#(
    parameter int SAMPLE_RATE = 48000,
    parameter int NUM_BANDS   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    obem_item_if.sink        item,
    obem_result_if.source    result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers: attack at byte 0, release at byte 4. The
    // register is picked by address bit 2; the low address bits are ignored.
    logic [23:0] attack_reg, attack_next;
    logic [23:0] release_reg, release_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        attack_next  = attack_reg;
        release_next = release_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ATTACK:  attack_next  = pwdata[23:0];
                REG_RELEASE: release_next = pwdata[23:0];
                default:     attack_next  = attack_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RESET;
            release_reg <= RELEASE_RESET;
        end
        else
        begin
            attack_reg  <= attack_next;
            release_reg <= release_next;
        end
    end

    // reads return the register value, zero-extended
    always_comb
    begin
        unique case (paddr[2])
            REG_ATTACK:  prdata = {8'b0, attack_reg};
            REG_RELEASE: prdata = {8'b0, release_reg};
            default:     prdata = '0;
        endcase
    end

    // Sequencer and datapath exchange only the command word.
    dp_cmd_t     cmd;
    logic [22:0] env_out [MAX_BANDS];

    obem_ctrl #(
        .NUM_BANDS (NUM_BANDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.op),
        .item_ready (item.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .cmd        (cmd)
    );

    obem_dp #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .NUM_BANDS   (NUM_BANDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample        (item.sample),
        .decay_factor  (item.decay_factor),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .env_out       (env_out)
    );

    // the result register drives the channel payload directly
    assign result.env_band_0 = env_out[0];
    assign result.env_band_1 = env_out[1];
    assign result.env_band_2 = env_out[2];
    assign result.env_band_3 = env_out[3];
    assign result.env_band_4 = env_out[4];
    assign result.env_band_5 = env_out[5];
    assign result.env_band_6 = env_out[6];
    assign result.env_band_7 = env_out[7];

endmodule

`default_nettype wire
